// ----- src/infix_expression_evaluator_assert.svh -----
// Assertion macros for the infix expression evaluator.
// Expects clk and arst_n in the including scope; synthesis sees empty bodies.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Implication checked on every clock edge outside reset
`define IEF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain property checked on every clock edge outside reset
`define IEF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`else

`define IEF_ASSERT_IMPL(label, ante, cons, msg)
`define IEF_ASSERT(label, prop, msg)

`endif

`endif

// ----- src/ief_pkg.sv -----
// Types and character codes of the infix expression evaluator.
// No dependencies.
`timescale 1ns / 1ps

package ief_pkg;

	// Width of the emitted value
	localparam int unsigned VALUE_W = 32;

	// Character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_TIMES = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Operator waiting for the next number
	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_SUB     = 3'd1,
		OP_MUL     = 3'd2,
		OP_DIV     = 3'd3,
		OP_DISCARD = 3'd4
	} pend_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_MUL,
		ST_DIV,
		ST_DIV_SIGN,
		ST_FINISH
	} ief_state_t;

endpackage

// ----- src/infix_expression_evaluator.sv -----
// Infix expression evaluator: character in, one result per '='.
// Depends on ief_pkg and infix_expression_evaluator_assert.svh.
`timescale 1ns / 1ps
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------
//  char     | char_valid / char_stall    | char_code[7:0]
//  result   | result_valid / result_stall| value[31:0], div_zero
//
// Digits and spaces are taken in the idle state. Any other character ends in the finish
// step, after the apply step when it ends a number; under '*' the multiply steps come
// between, under '/' with a nonzero divisor the divide and sign steps: the shift-add
// multiplier and the restoring divider retire one bit per cycle.
// Reset (arst_n low) clears the running total, term, number and flags at once.
// A '=' waits in the finish step while a previous result is still stalled.

`include "infix_expression_evaluator_assert.svh"

module infix_expression_evaluator
	import ief_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_code,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [VALUE_W-1:0] value,
	output logic               div_zero
);

	localparam int unsigned DW    = DATA_WIDTH;
	localparam int unsigned CNT_W = $clog2(DW);

	ief_state_t state_q, state_d;

	// Architectural state
	logic [DW-1:0] total_q, term_q, acc_q;
	pend_op_t      pend_op_q;
	logic          in_num_q, err_q;

	// Serial arithmetic work registers
	logic [DW-1:0]    a_q, b_q, r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [7:0]       char_q;

	// Output register
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               div_zero_q;

	logic          char_acc, is_space, is_digit, last_step, out_free, res_load;
	logic [3:0]    digit;
	logic [DW-1:0] sum, mul_next, div_trial, div_rem_next;
	logic [DW:0]   div_diff;
	logic          div_qbit;
	logic [VALUE_W-1:0] value_sum;

	// Character decode
	assign char_acc = char_valid && !char_stall;
	assign is_space = (char_code == CH_SPACE);
	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign digit    = 4'(char_code - CH_ZERO);

	assign last_step = (cnt_q == CNT_W'(DW - 1));
	assign out_free  = !out_valid_q || !result_stall;
	assign sum       = total_q + term_q;
	assign res_load  = (state_q == ST_FINISH) && (char_q == CH_EQUAL) && out_free;

	// One shift-add step: add multiplicand when the multiplier LSB is set
	assign mul_next = r_q + (b_q[0] ? a_q : '0);

	// One restoring-division step; remainder stays below divisor so its MSB is 0
	assign div_trial    = {r_q[DW-2:0], b_q[DW-1]};
	assign div_diff     = {1'b0, div_trial} - {1'b0, a_q};
	assign div_qbit     = !div_diff[DW];
	assign div_rem_next = div_qbit ? div_diff[DW-1:0] : div_trial;

	// Fit the result to the value port
	generate
		if (DW >= VALUE_W) begin : g_val_trunc
			assign value_sum = sum[VALUE_W-1:0];
		end else begin : g_val_ext
			assign value_sum = {{(VALUE_W - DW){1'b0}}, sum};
		end
	endgenerate

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d    = state_q;
		char_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (char_valid && !is_space && !is_digit) begin
					state_d = in_num_q ? ST_APPLY : ST_FINISH;
				end
			end
			ST_APPLY: begin
				case (pend_op_q)
					OP_MUL:  state_d = ST_MUL;
					OP_DIV:  state_d = (acc_q == '0) ? ST_FINISH : ST_DIV;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_MUL: begin
				if (last_step) begin
					state_d = ST_FINISH;
				end
			end
			ST_DIV: begin
				if (last_step) begin
					state_d = ST_DIV_SIGN;
				end
			end
			ST_DIV_SIGN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (char_q != CH_EQUAL || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Expression state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			term_q    <= '0;
			acc_q     <= '0;
			pend_op_q <= OP_ADD;
			in_num_q  <= 1'b0;
			err_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (char_acc && is_digit) begin
						acc_q    <= (acc_q << 3) + (acc_q << 1) + DW'(digit);
						in_num_q <= 1'b1;
					end
				end
				ST_APPLY: begin
					case (pend_op_q)
						OP_ADD: begin
							total_q <= sum;
							term_q  <= acc_q;
						end
						OP_SUB: begin
							total_q <= sum;
							term_q  <= '0 - acc_q;
						end
						OP_DIV: begin
							if (acc_q == '0) begin
								err_q <= 1'b1;
							end
						end
						default: begin
						end
					endcase
					acc_q    <= '0;
					in_num_q <= 1'b0;
				end
				ST_MUL: begin
					if (last_step) begin
						term_q <= mul_next;
					end
				end
				ST_DIV_SIGN: begin
					term_q <= neg_q ? ('0 - b_q) : b_q;
				end
				ST_FINISH: begin
					if (char_q == CH_EQUAL) begin
						if (out_free) begin
							total_q   <= '0;
							term_q    <= '0;
							acc_q     <= '0;
							pend_op_q <= OP_ADD;
							in_num_q  <= 1'b0;
							err_q     <= 1'b0;
						end
					end else begin
						case (char_q)
							CH_PLUS:  pend_op_q <= OP_ADD;
							CH_MINUS: pend_op_q <= OP_SUB;
							CH_TIMES: pend_op_q <= OP_MUL;
							CH_SLASH: pend_op_q <= OP_DIV;
							default:  pend_op_q <= OP_DISCARD;
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Serial multiply / divide datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (char_acc) begin
					char_q <= char_code;
				end
			end
			ST_APPLY: begin
				cnt_q <= '0;
				r_q   <= '0;
				if (pend_op_q == OP_MUL) begin
					a_q <= term_q;
					b_q <= acc_q;
				end else begin
					a_q   <= acc_q[DW-1] ? ('0 - acc_q) : acc_q;
					b_q   <= term_q[DW-1] ? ('0 - term_q) : term_q;
					neg_q <= acc_q[DW-1] ^ term_q[DW-1];
				end
			end
			ST_MUL: begin
				r_q   <= mul_next;
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_DIV: begin
				r_q   <= div_rem_next;
				b_q   <= {b_q[DW-2:0], div_qbit};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			value_q    <= value_sum;
			div_zero_q <= err_q;
		end
	end

	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign div_zero     = div_zero_q;

	// Checks
	`IEF_ASSERT_IMPL(a_result_src, $rose(result_valid), $past(res_load), "stray result")
	`IEF_ASSERT_IMPL(a_clear_after, $rose(result_valid), !(|{total_q, term_q, err_q}), "not cleared")
	`IEF_ASSERT_IMPL(a_rem_bound, state_q == ST_DIV, r_q < a_q, "remainder not below divisor")

endmodule

// ----- bench/infix_expression_evaluator_test.sv -----
// Self-checking bench for the infix expression evaluator: a directed table, then random expressions.
// Depends on ief_pkg and the infix_expression_evaluator RTL.
`timescale 1ns / 1ps

module infix_expression_evaluator_test;
	import ief_pkg::*;

	localparam int unsigned RANDOM_CHARS = 1500;
	localparam int unsigned CYCLE_LIMIT  = 600000;
	// longest character runs through the divide steps; leave margin after the last result
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned DIR_COUNT    = 37;

	// One emitted expression value
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      div_zero;
	} outcome_t;

	// One row of the directed table; typed rows carry their result
	typedef struct packed {
		logic [7:0]         ch;
		logic               typed;
		logic [VALUE_W-1:0] value;
		logic               div_zero;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               char_valid = 1'b0;
	logic               char_stall;
	logic [7:0]         char_code = 8'h00;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [VALUE_W-1:0] value;
	logic               div_zero;

	// Evaluator state mirrored by the predictor
	logic [VALUE_W-1:0] run_total;
	logic [VALUE_W-1:0] run_term;
	logic [VALUE_W-1:0] num_acc;
	pend_op_t           pend;
	bit                 in_num;
	bit                 div_fault;

	outcome_t     pending_results [$];
	int unsigned  n_errors = 0;
	int unsigned  n_sent = 0;
	int unsigned  cycle_count = 0;
	int           src_idle_pct = 0;
	int           sink_stall_pct = 0;

	// Empty expression, then divide by zero with noise, stacked operators and a space,
	// then most negative over a wrapped -1
	dir_row_t dir_rows [DIR_COUNT] = '{
		'{CH_EQUAL, 1'b1, 32'd0, 1'b0},
		'{"8", 1'b0, 32'd0, 1'b0},      '{CH_SLASH, 1'b0, 32'd0, 1'b0},
		'{CH_SPACE, 1'b0, 32'd0, 1'b0}, '{"0", 1'b0, 32'd0, 1'b0},
		'{8'h00, 1'b0, 32'd0, 1'b0},    '{"9", 1'b0, 32'd0, 1'b0},
		'{8'hFF, 1'b0, 32'd0, 1'b0},    '{CH_PLUS, 1'b0, 32'd0, 1'b0},
		'{CH_MINUS, 1'b0, 32'd0, 1'b0}, '{CH_TIMES, 1'b0, 32'd0, 1'b0},
		'{"3", 1'b0, 32'd0, 1'b0},      '{CH_MINUS, 1'b0, 32'd0, 1'b0},
		'{"1", 1'b0, 32'd0, 1'b0},      '{CH_EQUAL, 1'b1, 32'd23, 1'b1},
		'{"2", 1'b0, 32'd0, 1'b0},      '{"1", 1'b0, 32'd0, 1'b0},
		'{"4", 1'b0, 32'd0, 1'b0},      '{"7", 1'b0, 32'd0, 1'b0},
		'{"4", 1'b0, 32'd0, 1'b0},      '{"8", 1'b0, 32'd0, 1'b0},
		'{"3", 1'b0, 32'd0, 1'b0},      '{"6", 1'b0, 32'd0, 1'b0},
		'{"4", 1'b0, 32'd0, 1'b0},      '{"8", 1'b0, 32'd0, 1'b0},
		'{CH_SLASH, 1'b0, 32'd0, 1'b0},
		'{"8", 1'b0, 32'd0, 1'b0},      '{"5", 1'b0, 32'd0, 1'b0},
		'{"8", 1'b0, 32'd0, 1'b0},      '{"9", 1'b0, 32'd0, 1'b0},
		'{"9", 1'b0, 32'd0, 1'b0},      '{"3", 1'b0, 32'd0, 1'b0},
		'{"4", 1'b0, 32'd0, 1'b0},      '{"5", 1'b0, 32'd0, 1'b0},
		'{"9", 1'b0, 32'd0, 1'b0},      '{"1", 1'b0, 32'd0, 1'b0},
		'{CH_EQUAL, 1'b1, 32'h8000_0000, 1'b0}
	};

	infix_expression_evaluator #(
		.DATA_WIDTH(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.value(value),
		.div_zero(div_zero)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("infix_expression_evaluator_test: errors");
			$finish;
		end
	end

	// Receiver stall, changed on the falling edge
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, $signed(got), $signed(want));
		n_errors++;
	endtask

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none expected", value, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value)
					report_mismatch("value", value, want.value);
				if (div_zero !== want.div_zero)
					report_mismatch("div_zero", {31'd0, div_zero}, {31'd0, want.div_zero});
			end
		end
	end

	task automatic clear_state();
		run_total = '0;
		run_term  = '0;
		num_acc   = '0;
		pend      = OP_ADD;
		in_num    = 1'b0;
		div_fault = 1'b0;
	endtask

	// Predictor: advance the evaluator by one character
	task automatic eval_char(input logic [7:0] ch, output bit emits, output outcome_t res);
		logic [VALUE_W-1:0] mag_a;
		logic [VALUE_W-1:0] mag_b;
		logic [VALUE_W-1:0] quot;
		emits = 1'b0;
		res = '0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			num_acc = num_acc * 32'd10 + 32'(ch - CH_ZERO);
			in_num = 1'b1;
		end else if (ch != CH_SPACE) begin
			// a finished number is applied by the waiting operator
			if (in_num) begin
				case (pend)
					OP_ADD: begin
						run_total = run_total + run_term;
						run_term = num_acc;
					end
					OP_SUB: begin
						run_total = run_total + run_term;
						run_term = -num_acc;
					end
					OP_MUL: run_term = run_term * num_acc;
					OP_DIV: begin
						if (num_acc == '0) begin
							div_fault = 1'b1;
						end else begin
							// truncate toward zero on magnitudes
							mag_a = run_term[VALUE_W-1] ? -run_term : run_term;
							mag_b = num_acc[VALUE_W-1] ? -num_acc : num_acc;
							quot = mag_a / mag_b;
							run_term = (run_term[VALUE_W-1] ^ num_acc[VALUE_W-1]) ? -quot : quot;
						end
					end
					default: ;
				endcase
				num_acc = '0;
				in_num = 1'b0;
			end
			if (ch == CH_EQUAL) begin
				emits = 1'b1;
				res.value = run_total + run_term;
				res.div_zero = div_fault;
				clear_state();
			end else begin
				case (ch)
					CH_PLUS:  pend = OP_ADD;
					CH_MINUS: pend = OP_SUB;
					CH_TIMES: pend = OP_MUL;
					CH_SLASH: pend = OP_DIV;
					default:  pend = OP_DISCARD;
				endcase
			end
		end
	endtask

	// Present one request, wait for acceptance, record what it should produce
	task automatic feed_char(input logic [7:0] ch, input bit typed, input outcome_t typed_res);
		outcome_t res;
		bit emits;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_code <= ch;
		do @(posedge clk); while (char_stall);
		if (ch != CH_SPACE)
			n_sent++;
		eval_char(ch, emits, res);
		if (emits)
			pending_results.push_back(typed ? typed_res : res);
	endtask

	task automatic put(input logic [7:0] ch);
		feed_char(ch, 1'b0, '0);
	endtask

	// Random number, mostly short; a few long ones wrap the accumulator
	task automatic put_number(input bit as_zero);
		int n_digits;
		int sel;
		sel = $urandom_range(0, 99);
		if (as_zero)
			n_digits = $urandom_range(1, 2);
		else if (sel < 80)
			n_digits = $urandom_range(1, 3);
		else if (sel < 95)
			n_digits = $urandom_range(4, 6);
		else
			n_digits = $urandom_range(10, 12);
		for (int i = 0; i < n_digits; i++) begin
			if (i > 0 && $urandom_range(0, 19) == 0)
				put(CH_SPACE);
			put(as_zero ? CH_ZERO : CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	// Hold off the sender until every expected result has come back
	task automatic drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_phase(input int p);
		case (p)
			0: begin
				src_idle_pct = 9;
				sink_stall_pct = 81;
			end
			1: begin
				src_idle_pct = 81;
				sink_stall_pct = 9;
			end
			default: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
		endcase
	endtask

	initial begin
		outcome_t row_res;
		logic [7:0] op_set [4];
		logic [7:0] op;
		int phase;
		int next_phase;
		int kind;
		int n_terms;
		int r;

		op_set = '{CH_PLUS, CH_MINUS, CH_TIMES, CH_SLASH};
		clear_state();
		phase = 0;
		set_phase(phase);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (int i = 0; i < DIR_COUNT; i++) begin
			row_res.value = dir_rows[i].value;
			row_res.div_zero = dir_rows[i].div_zero;
			feed_char(dir_rows[i].ch, dir_rows[i].typed, row_res);
		end
		drain();
		n_sent = 0;

		// Random expressions: mostly well formed, some noise and broken ones
		while (n_sent < RANDOM_CHARS) begin
			next_phase = (n_sent * 3) / RANDOM_CHARS;
			if (next_phase != phase) begin
				drain();
				phase = next_phase;
				set_phase(phase);
			end
			kind = $urandom_range(0, 99);
			if (kind >= 4) begin
				// leading junk: one to four random bytes
				if (kind < 12) begin
					repeat ($urandom_range(1, 4))
						put(8'($urandom_range(0, 255)));
				end
				n_terms = $urandom_range(1, 5);
				op = CH_PLUS;
				for (int t = 0; t < n_terms; t++) begin
					if (t > 0) begin
						r = $urandom_range(0, 99);
						if (r < 6)
							put(8'($urandom_range(0, 255)));
						else if (r < 14)
							put(op_set[$urandom_range(0, 3)]);
						op = op_set[$urandom_range(0, 3)];
						put(op);
						if ($urandom_range(0, 9) == 0)
							put(CH_SPACE);
					end
					put_number(op == CH_SLASH && $urandom_range(0, 9) == 0);
				end
			end
			put(CH_EQUAL);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("infix_expression_evaluator_test: clean");
		else
			$display("infix_expression_evaluator_test: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/ief_pkg.sv
src/infix_expression_evaluator.sv
bench/infix_expression_evaluator_test.sv
